FILE: sv/lkrl_pkg.sv
package lkrl_pkg;

  localparam int LEVELS  = 8;
  localparam int ENTRIES = 16;
  localparam int SLOTS   = LEVELS * ENTRIES;

  localparam int OP_W   = 2;
  localparam int LVL_W  = 3;
  localparam int IDX_W  = 4;
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;
  localparam int LVA_W  = $clog2(LEVELS);
  localparam int LCNT_W = $clog2(LEVELS + 1);
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 24;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE   = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              wr_en;
    logic              wr_from_in;
    logic [SLOT_W-1:0] wr_slot;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_a_slot;
    logic [SLOT_W-1:0] rd_b_slot;
    logic [SLOT_W-1:0] rd_m_slot;
    logic              chk;
    logic              eval;
    logic              eval_more;
    logic [IDX_W-1:0]  eval_idx;
    logic              out_load;
    logic [ST_W-1:0]   out_status;
    logic [CNT_W-1:0]  out_cnt;
  } lkrl_cmd_t;

  typedef struct packed {
    logic no_overlap;
    logic out_free;
  } lkrl_sts_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [LVL_W-1:0] lv,
                                                input logic [IDX_W-1:0] idx);
    slot_of = SLOT_W'(SLOT_W'(lv) * SLOT_W'(ENTRIES)) + SLOT_W'(idx);
  endfunction

endpackage

FILE: sv/lkrl_datapath.sv
module lkrl_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lkrl_pkg::lkrl_cmd_t               cmd,
  output lkrl_pkg::lkrl_sts_t               sts,
  input  logic [lkrl_pkg::KEY_W-1:0]        in_key_low,
  input  logic [lkrl_pkg::KEY_W-1:0]        in_key_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lkrl_pkg::ST_W-1:0]         out_status,
  output logic [lkrl_pkg::IDX_W-1:0]        out_first_index,
  output logic                              out_first_found,
  output logic [lkrl_pkg::IDX_W-1:0]        out_last_index,
  output logic                              out_last_found,
  output logic [lkrl_pkg::CNT_W-1:0]        out_entry_count
);
  import lkrl_pkg::*;

  logic [KEY_W-1:0] min_mem [SLOTS];
  logic [KEY_W-1:0] max_mem [SLOTS];

  logic [KEY_W-1:0] k1_r, k2_r;
  logic [KEY_W-1:0] rd_min_a_r, rd_min_b_r, rd_max_r;
  logic [IDX_W-1:0] f1_r, f2_r;
  logic             g1_r, g2_r;
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [IDX_W-1:0] out_f1_r, out_f2_r;
  logic             out_g1_r, out_g2_r;
  logic [IDX_W-1:0] eval_inc;

  assign eval_inc = cmd.eval_idx + 1'b1;

  // During the check step port A holds the first min, port B the last min
  // and the max port the last max of the level.
  assign sts.no_overlap = (k1_r < rd_min_a_r && k2_r < rd_min_a_r) ||
                          (k1_r > rd_max_r && k2_r > rd_max_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      min_mem[cmd.wr_slot] <= cmd.wr_from_in ? k1_r : rd_min_a_r;
      max_mem[cmd.wr_slot] <= cmd.wr_from_in ? k2_r : rd_max_r;
    end
    if (cmd.rd_en) begin
      rd_min_a_r <= min_mem[cmd.rd_a_slot];
      rd_min_b_r <= min_mem[cmd.rd_b_slot];
      rd_max_r   <= max_mem[cmd.rd_m_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k1_r <= in_key_low;
      k2_r <= in_key_high;
      f1_r <= '0;
      g1_r <= 1'b0;
      f2_r <= '0;
      g2_r <= 1'b0;
    end else if (cmd.chk) begin
      if (!sts.no_overlap) begin
        if (k1_r < rd_min_a_r) begin
          f1_r <= '0;
          g1_r <= 1'b1;
        end
        if (k2_r > rd_min_b_r) begin
          f2_r <= cmd.eval_idx;
          g2_r <= 1'b1;
        end
      end
    end else if (cmd.eval) begin
      // Port A is this entry's min, port B the next entry's min.
      if (k1_r >= rd_min_a_r && k1_r <= rd_max_r) begin
        f1_r <= cmd.eval_idx;
        g1_r <= 1'b1;
      end else if (cmd.eval_more && k1_r > rd_max_r && k1_r < rd_min_b_r) begin
        f1_r <= eval_inc;
        g1_r <= 1'b1;
      end
      if (k2_r >= rd_min_a_r && k2_r <= rd_max_r) begin
        f2_r <= cmd.eval_idx;
        g2_r <= 1'b1;
      end else if (cmd.eval_more && k2_r > rd_max_r && k2_r < rd_min_b_r) begin
        f2_r <= eval_inc;
        g2_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The search registers are reused by the next word, so the result is
  // held in its own register while it waits.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_cnt_r    <= cmd.out_cnt;
      out_f1_r     <= f1_r;
      out_g1_r     <= g1_r;
      out_f2_r     <= f2_r;
      out_g2_r     <= g2_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_index = out_f1_r;
  assign out_first_found = out_g1_r;
  assign out_last_index  = out_f2_r;
  assign out_last_found  = out_g2_r;
  assign out_entry_count = out_cnt_r;

endmodule

FILE: sv/lkrl_ctrl.sv
module lkrl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lkrl_pkg::OP_W-1:0]   in_op,
  input  logic [lkrl_pkg::LVL_W-1:0]  in_level_sel,
  input  logic [lkrl_pkg::IDX_W-1:0]  in_entry_index,
  output lkrl_pkg::lkrl_cmd_t         cmd,
  input  lkrl_pkg::lkrl_sts_t         sts
);
  import lkrl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FRD   = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LCNT_W-1:0] lc_r, lc_nxt;
  logic [CNT_W-1:0]  cnt_r [LEVELS];
  logic [CNT_W-1:0]  cnt_nxt [LEVELS];
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              wp_r, wp_nxt;
  logic [IDX_W-1:0]  wdst_r, wdst_nxt;
  logic              ev_r, ev_nxt;
  logic [IDX_W-1:0]  ev_i_r, ev_i_nxt;
  logic              ev_more_r, ev_more_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic [LCNT_W-1:0] lv_e;
  logic [LVA_W-1:0]  lv_a;
  logic              lv_ok, lv_open;
  logic [CNT_W-1:0]  n_cur, n_app, n_app_inc, n_cur_dec, n_open;
  logic [CNT_W-1:0]  ptr_inc, nm1;
  logic              rd_go;

  assign lv_e      = LCNT_W'(lv_r);
  assign lv_a      = lv_r[LVA_W-1:0];
  assign lv_ok     = lv_e < LCNT_W'(LEVELS);
  assign lv_open   = lv_ok && (lv_e < lc_r);
  assign n_cur     = cnt_r[lv_a];
  assign n_app     = (lv_e == lc_r) ? '0 : n_cur;
  assign n_app_inc = n_app + 1'b1;
  assign n_cur_dec = n_cur - 1'b1;
  assign n_open    = lv_open ? n_cur : '0;
  assign ptr_inc   = ptr_r + 1'b1;
  assign nm1       = n_r - 1'b1;
  assign rd_go     = ptr_inc < n_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    lv_nxt      = lv_r;
    idx_nxt     = idx_r;
    lc_nxt      = lc_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    ptr_nxt     = ptr_r;
    wp_nxt      = wp_r;
    wdst_nxt    = wdst_r;
    ev_nxt      = ev_r;
    ev_i_nxt    = ev_i_r;
    ev_more_nxt = ev_more_r;
    res_st_nxt  = res_st_r;
    res_cnt_nxt = res_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt      = in_op;
          lv_nxt      = in_level_sel;
          idx_nxt     = in_entry_index;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt   = S_OUT;
        res_st_nxt  = ST_REJECT;
        res_cnt_nxt = n_open;
        unique case (op_r)
          OP_APPEND: begin
            res_cnt_nxt = '0;
            if (lv_ok && lv_e <= lc_r) begin
              if (lv_e == lc_r) begin
                lc_nxt        = lc_r + 1'b1;
                cnt_nxt[lv_a] = '0;
              end
              res_cnt_nxt = n_app;
              if (n_app < CNT_W'(ENTRIES)) begin
                cmd.wr_en      = 1'b1;
                cmd.wr_from_in = 1'b1;
                cmd.wr_slot    = slot_of(lv_r, n_app[IDX_W-1:0]);
                cnt_nxt[lv_a]  = n_app_inc;
                res_st_nxt     = ST_OK;
                res_cnt_nxt    = n_app_inc;
              end
            end
          end
          OP_DELETE: begin
            if (lv_open && CNT_W'(idx_r) < n_cur) begin
              cnt_nxt[lv_a] = n_cur_dec;
              res_st_nxt    = ST_OK;
              res_cnt_nxt   = n_cur_dec;
              n_nxt         = n_cur;
              ptr_nxt       = CNT_W'(idx_r);
              wp_nxt        = 1'b0;
              state_nxt     = S_SHIFT;
            end
          end
          OP_FIND: begin
            res_st_nxt = ST_NONE;
            if (lv_open && n_cur != '0) begin
              n_nxt     = n_cur;
              state_nxt = S_FRD;
            end
          end
          default: begin
            res_st_nxt = ST_REJECT;
          end
        endcase
      end
      S_SHIFT: begin
        // Read of entry ptr+1 overlaps the write of the previous entry down.
        if (rd_go) begin
          cmd.rd_en     = 1'b1;
          cmd.rd_a_slot = slot_of(lv_r, ptr_inc[IDX_W-1:0]);
          cmd.rd_b_slot = slot_of(lv_r, ptr_inc[IDX_W-1:0]);
          cmd.rd_m_slot = slot_of(lv_r, ptr_inc[IDX_W-1:0]);
        end
        if (wp_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_slot = slot_of(lv_r, wdst_r);
        end
        wp_nxt   = rd_go;
        wdst_nxt = ptr_r[IDX_W-1:0];
        ptr_nxt  = ptr_inc;
        if (!rd_go && !wp_r) begin
          state_nxt = S_OUT;
        end
      end
      S_FRD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_slot = slot_of(lv_r, '0);
        cmd.rd_b_slot = slot_of(lv_r, nm1[IDX_W-1:0]);
        cmd.rd_m_slot = slot_of(lv_r, nm1[IDX_W-1:0]);
        state_nxt     = S_FCHK;
      end
      S_FCHK: begin
        cmd.chk      = 1'b1;
        cmd.eval_idx = nm1[IDX_W-1:0];
        if (sts.no_overlap) begin
          res_st_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end else begin
          res_st_nxt = ST_OK;
          ptr_nxt    = '0;
          ev_nxt     = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.eval      = ev_r;
        cmd.eval_idx  = ev_i_r;
        cmd.eval_more = ev_more_r;
        if (ptr_r < n_r) begin
          cmd.rd_en     = 1'b1;
          cmd.rd_a_slot = slot_of(lv_r, ptr_r[IDX_W-1:0]);
          cmd.rd_b_slot = slot_of(lv_r, ptr_inc[IDX_W-1:0]);
          cmd.rd_m_slot = slot_of(lv_r, ptr_r[IDX_W-1:0]);
          ev_nxt        = 1'b1;
          ev_i_nxt      = ptr_r[IDX_W-1:0];
          ev_more_nxt   = rd_go;
          ptr_nxt       = ptr_inc;
        end else begin
          ev_nxt = 1'b0;
          if (!ev_r) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_st_r;
          cmd.out_cnt    = res_cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lc_r    <= '0;
      wp_r    <= 1'b0;
      ev_r    <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      wp_r    <= wp_nxt;
      ev_r    <= ev_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    lv_r      <= lv_nxt;
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    ptr_r     <= ptr_nxt;
    wdst_r    <= wdst_nxt;
    ev_i_r    <= ev_i_nxt;
    ev_more_r <= ev_more_nxt;
    res_st_r  <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

endmodule

FILE: sv/leveled_key_range_locator_unit.sv
// One word in, one word out; a word is accepted only while no other is in progress.
// Append, rejected and unused-opcode words and finds on an absent or empty level go from decode
// straight to the output step; a delete first moves each later entry of the level down one place,
// and a find reads the level's bounds, checks whether the range overlaps them and only then
// scans the entries. The next word is accepted the cycle after the result is loaded.
// Synchronous active-low reset closes all levels; the interval memories are not cleared.
module leveled_key_range_locator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // level_sel[2:0], entry_index[6:3], key_low[70:7], key_high[134:71], zero fill
  input  logic [lkrl_pkg::IN_DATA_W-1:0]      in_tdata,
  // op[1:0]
  input  logic [lkrl_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], first_index[5:2], first_found[6], last_index[10:7],
  // last_found[11], entry_count[16:12], zero fill
  output logic [lkrl_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import lkrl_pkg::*;

  lkrl_cmd_t        cmd;
  lkrl_sts_t        sts;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] first_index, last_index;
  logic             first_found, last_found;
  logic [CNT_W-1:0] entry_count;

  lkrl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_op          (in_tuser),
    .in_level_sel   (in_tdata[2:0]),
    .in_entry_index (in_tdata[6:3]),
    .cmd            (cmd),
    .sts            (sts)
  );

  lkrl_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_key_low      (in_tdata[70:7]),
    .in_key_high     (in_tdata[134:71]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (status),
    .out_first_index (first_index),
    .out_first_found (first_found),
    .out_last_index  (last_index),
    .out_last_found  (last_found),
    .out_entry_count (entry_count)
  );

  assign out_tdata = {7'd0, entry_count, last_found, last_index,
                      first_found, first_index, status};

endmodule
